// ===== rtl/ate_pkg.sv =====
// Shared constants and types for the array table engine.
// No dependencies.
package ate_pkg;

   localparam int DEPTH   = 256;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = IDX_W + 1;
   localparam int DATA_W  = 32;
   localparam int FOUND_W = 8;

   localparam logic [2:0] OP_APPEND       = 3'd0;
   localparam logic [2:0] OP_INSERT_AT    = 3'd1;
   localparam logic [2:0] OP_REMOVE_FIRST = 3'd2;
   localparam logic [2:0] OP_REMOVE_ALL   = 3'd3;
   localparam logic [2:0] OP_REMOVE_AT    = 3'd4;
   localparam logic [2:0] OP_FIND         = 3'd5;
   localparam logic [2:0] OP_BSEARCH      = 3'd6;
   localparam logic [2:0] OP_SORT         = 3'd7;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_BAD_POS   = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic               valid;
      logic [1:0]         status;
      logic [FOUND_W-1:0] found_index;
      logic [CNT_W-1:0]   entry_count;
   } result_type;

endpackage

// ===== rtl/ate_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ate_ram #(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/ate_seq.sv =====
// Operation sequencer: walks the entry RAM for shifts, compaction, search and sort.
// Depends on ate_pkg and ate_ram.
module ate_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic [2:0]                     op,
   input  logic signed [31:0]             value,
   input  logic [7:0]                     position,
   input  logic [ate_pkg::CNT_W-1:0]      capacity,
   input  logic                           take,
   output logic                           busy,
   output ate_pkg::result_type            res
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_BS_RD    = 3'd2;
   localparam logic [2:0] S_BS_CMP   = 3'd3;
   localparam logic [2:0] S_SORT_END = 3'd4;
   localparam logic [2:0] S_WRITE    = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   localparam logic [1:0] K_FIND    = 2'd0;
   localparam logic [1:0] K_COMPACT = 2'd1;
   localparam logic [1:0] K_SHIFT   = 2'd2;
   localparam logic [1:0] K_SORT    = 2'd3;

   localparam int IW = ate_pkg::IDX_W;
   localparam int CW = ate_pkg::CNT_W;
   localparam int DW = ate_pkg::DATA_W;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        kind_ff, kind_in;
   logic [2:0]        op_ff, op_in;
   logic [DW-1:0]     val_ff, val_in;
   logic [IW-1:0]     pos_ff, pos_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     ra_ff, ra_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic              down_ff, down_in;
   logic              pv_ff, pv_in;
   logic [IW-1:0]     pidx_ff, pidx_in;
   logic [CW-1:0]     wp_ff, wp_in;
   logic              removed_ff, removed_in;
   logic [DW-1:0]     cur_ff, cur_in;
   logic              swapped_ff, swapped_in;
   logic [CW-1:0]     last_ff, last_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hx_ff, hx_in;
   logic [IW-1:0]     mid_ff, mid_in;
   logic [1:0]        status_ff, status_in;
   logic [ate_pkg::FOUND_W-1:0] found_ff, found_in;

   logic              mem_we;
   logic [IW-1:0]     mem_waddr, mem_raddr;
   logic [DW-1:0]     mem_wdata, mem_rdata;

   logic [CW-1:0]     limit;
   logic              full;
   logic              issue;
   logic              match;
   logic              skip;
   logic [CW:0]       mid_sum;
   logic [CW-1:0]     pos_ext;

   ate_ram #(.DATA_W(DW), .ADDR_W(IW)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign limit   = (capacity < CW'(ate_pkg::DEPTH)) ? capacity : CW'(ate_pkg::DEPTH);
   assign full    = cnt_ff >= limit;
   assign issue   = rem_ff != '0;
   assign match   = mem_rdata == val_ff;
   assign pos_ext = CW'(position);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hx_ff} - (CW+1)'(1);

   always_comb begin
      unique case (op_ff)
         ate_pkg::OP_REMOVE_AT:    skip = pidx_ff == pos_ff;
         ate_pkg::OP_REMOVE_FIRST: skip = match && !removed_ff;
         ate_pkg::OP_REMOVE_ALL:   skip = match;
         default:                  skip = 1'b0;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      op_in      = op_ff;
      val_in     = val_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      ra_in      = ra_ff;
      rem_in     = rem_ff;
      down_in    = down_ff;
      pv_in      = 1'b0;
      pidx_in    = pidx_ff;
      wp_in      = wp_ff;
      removed_in = removed_ff;
      cur_in     = cur_ff;
      swapped_in = swapped_ff;
      last_in    = last_ff;
      lo_in      = lo_ff;
      hx_in      = hx_ff;
      mid_in     = mid_ff;
      status_in  = status_ff;
      found_in   = found_ff;
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wdata  = '0;
      mem_raddr  = ra_ff[IW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (go) begin
               op_in      = op;
               val_in     = value;
               pos_in     = position[IW-1:0];
               status_in  = ate_pkg::ST_OK;
               found_in   = '0;
               removed_in = 1'b0;
               swapped_in = 1'b0;
               down_in    = 1'b0;
               ra_in      = '0;
               rem_in     = cnt_ff;
               wp_in      = '0;
               unique case (op)
                  ate_pkg::OP_APPEND: begin
                     if (full) begin
                        status_in = ate_pkg::ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        pos_in   = cnt_ff[IW-1:0];
                        state_in = S_WRITE;
                     end
                  end
                  ate_pkg::OP_INSERT_AT: begin
                     if (pos_ext > cnt_ff) begin
                        status_in = ate_pkg::ST_BAD_POS;
                        state_in  = S_DONE;
                     end else if (full) begin
                        status_in = ate_pkg::ST_FULL;
                        state_in  = S_DONE;
                     end else if (pos_ext == cnt_ff) begin
                        state_in = S_WRITE;
                     end else begin
                        kind_in  = K_SHIFT;
                        down_in  = 1'b1;
                        ra_in    = cnt_ff - CW'(1);
                        rem_in   = cnt_ff - pos_ext;
                        state_in = S_SCAN;
                     end
                  end
                  ate_pkg::OP_REMOVE_FIRST, ate_pkg::OP_REMOVE_ALL: begin
                     kind_in  = K_COMPACT;
                     state_in = S_SCAN;
                  end
                  ate_pkg::OP_REMOVE_AT: begin
                     if (pos_ext >= cnt_ff) begin
                        status_in = ate_pkg::ST_BAD_POS;
                        state_in  = S_DONE;
                     end else begin
                        kind_in  = K_COMPACT;
                        ra_in    = pos_ext;
                        wp_in    = pos_ext;
                        rem_in   = cnt_ff - pos_ext;
                        state_in = S_SCAN;
                     end
                  end
                  ate_pkg::OP_FIND: begin
                     kind_in  = K_FIND;
                     state_in = S_SCAN;
                  end
                  ate_pkg::OP_BSEARCH: begin
                     lo_in    = '0;
                     hx_in    = cnt_ff;
                     state_in = S_BS_RD;
                  end
                  default: begin
                     if (cnt_ff > CW'(1)) begin
                        kind_in  = K_SORT;
                        last_in  = cnt_ff;
                        state_in = S_SCAN;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (issue) begin
               pv_in   = 1'b1;
               pidx_in = ra_ff[IW-1:0];
               rem_in  = rem_ff - CW'(1);
               ra_in   = down_ff ? ra_ff - CW'(1) : ra_ff + CW'(1);
            end
            if (pv_ff) begin
               unique case (kind_ff)
                  K_FIND: begin
                     if (match) begin
                        found_in  = ate_pkg::FOUND_W'(pidx_ff);
                        status_in = ate_pkg::ST_OK;
                        rem_in    = '0;
                        pv_in     = 1'b0;
                        state_in  = S_DONE;
                     end
                  end
                  K_COMPACT: begin
                     if (skip) begin
                        removed_in = 1'b1;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = wp_ff[IW-1:0];
                        mem_wdata = mem_rdata;
                        wp_in     = wp_ff + CW'(1);
                     end
                  end
                  K_SHIFT: begin
                     mem_we    = 1'b1;
                     mem_waddr = pidx_ff + IW'(1);
                     mem_wdata = mem_rdata;
                  end
                  default: begin
                     if (pidx_ff == '0) begin
                        cur_in = mem_rdata;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = pidx_ff - IW'(1);
                        if ($signed(mem_rdata) < $signed(cur_ff)) begin
                           mem_wdata  = mem_rdata;
                           swapped_in = 1'b1;
                        end else begin
                           mem_wdata = cur_ff;
                           cur_in    = mem_rdata;
                        end
                     end
                  end
               endcase
            end else if (!issue) begin
               unique case (kind_ff)
                  K_FIND: begin
                     status_in = ate_pkg::ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end
                  K_COMPACT: begin
                     cnt_in    = wp_ff;
                     status_in = removed_ff ? ate_pkg::ST_OK : ate_pkg::ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end
                  K_SHIFT:  state_in = S_WRITE;
                  default:  state_in = S_SORT_END;
               endcase
            end
         end

         S_SORT_END: begin
            mem_we    = 1'b1;
            mem_waddr = IW'(last_ff - CW'(1));
            mem_wdata = cur_ff;
            if (swapped_ff && last_ff > CW'(2)) begin
               last_in    = last_ff - CW'(1);
               rem_in     = last_ff - CW'(1);
               ra_in      = '0;
               swapped_in = 1'b0;
               state_in   = S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end

         S_BS_RD: begin
            mem_raddr = mid_sum[IW:1];
            mid_in    = mid_sum[IW:1];
            if (lo_ff < hx_ff) begin
               state_in = S_BS_CMP;
            end else begin
               status_in = ate_pkg::ST_NOT_FOUND;
               state_in  = S_DONE;
            end
         end

         S_BS_CMP: begin
            if (match) begin
               found_in  = ate_pkg::FOUND_W'(mid_ff);
               status_in = ate_pkg::ST_OK;
               state_in  = S_DONE;
            end else if ($signed(val_ff) < $signed(mem_rdata)) begin
               hx_in    = CW'(mid_ff);
               state_in = S_BS_RD;
            end else begin
               lo_in    = CW'(mid_ff) + CW'(1);
               state_in = S_BS_RD;
            end
         end

         S_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = val_ff;
            cnt_in    = cnt_ff + CW'(1);
            status_in = ate_pkg::ST_OK;
            state_in  = S_DONE;
         end

         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pv_ff    <= 1'b0;
         rem_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pv_ff    <= pv_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      op_ff      <= op_in;
      val_ff     <= val_in;
      pos_ff     <= pos_in;
      ra_ff      <= ra_in;
      down_ff    <= down_in;
      pidx_ff    <= pidx_in;
      wp_ff      <= wp_in;
      removed_ff <= removed_in;
      cur_ff     <= cur_in;
      swapped_ff <= swapped_in;
      last_ff    <= last_in;
      lo_ff      <= lo_in;
      hx_ff      <= hx_in;
      mid_ff     <= mid_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
   end

   assign busy            = state_ff != S_IDLE;
   assign res.valid       = state_ff == S_DONE;
   assign res.status      = status_ff;
   assign res.found_index = found_ff;
   assign res.entry_count = cnt_ff;

endmodule

// ===== rtl/array_table_engine_core.sv =====
// Array table engine top level: request/response channels, capacity register, result register.
// Depends on ate_pkg and ate_seq.
// One request is processed at a time; the request channel stalls until the result is handed
// to the output register, which may still hold the previous result. Append and insert at the
// end write the entry directly; insert, the removals and find stream through the entry RAM at
// one entry per cycle; binary search takes a read state and a compare state per halving step;
// sort runs bubble passes, each ending with a write-back of the carried entry. The entry RAM
// has a single read and a single write port and registered read data.
module array_table_engine_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_operation,
   input  logic signed [31:0]            req_value,
   input  logic [7:0]                    req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [7:0]                    rsp_found_index,
   output logic [8:0]                    rsp_entry_count,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic [8:0]                cap_ff, cap_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                status_ff;
   logic [7:0]                found_ff;
   logic [8:0]                count_ff;
   logic                      go;
   logic                      load;
   logic                      busy;
   ate_pkg::result_type       res;

   assign pready = 1'b1;
   assign cap_in = (psel && penable && pwrite && pready && !paddr[2]) ? pwdata[8:0] : cap_ff;
   assign prdata = paddr[2] ? 32'd0 : {23'd0, cap_ff};

   assign go        = req_valid && !req_stall;
   assign req_stall = busy;
   assign load      = res.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   ate_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .op       (req_operation),
      .value    (req_value),
      .position (req_position),
      .capacity (cap_ff),
      .take     (load),
      .busy     (busy),
      .res      (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= 9'd256;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= res.status;
         found_ff  <= res.found_index;
         count_ff  <= res.entry_count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_index = found_ff;
   assign rsp_entry_count = count_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("engine idle right after a request transfer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= 9'(ate_pkg::DEPTH))
      else $error("entry count above table depth");

   a_fail_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ate_pkg::ST_OK |-> rsp_found_index == 8'd0)
      else $error("found index set on a failed request");

endmodule

// ===== tb/tb_array_table_engine_core.sv =====
// Self-checking testbench for array_table_engine_core: directed and random table operations,
// checked against a behavioral table model held in a scoreboard class.
// Depends on ate_pkg and the array_table_engine_core RTL.
`timescale 1ns / 100ps

module tb_array_table_engine_core;

   localparam logic [2:0] CAP_ADDR = 3'd0;

   typedef struct {
      logic [1:0] status;
      logic [7:0] found_index;
      logic [8:0] entry_count;
   } table_answer_type;

   class table_scoreboard;
      logic signed [31:0] tbl [ate_pkg::DEPTH];
      int                 cnt;
      int                 cap;
      int                 errors;
      table_answer_type   expected_answers [$];

      function new();
         cnt = 0;
         cap = 256;
         errors = 0;
      endfunction

      function int limit();
         return (cap < ate_pkg::DEPTH) ? cap : ate_pkg::DEPTH;
      endfunction

      function void drop(int at);
         for (int k = at; k + 1 < cnt; k++) tbl[k] = tbl[k+1];
         cnt--;
      endfunction

      function void note_request(logic [2:0] op, logic signed [31:0] v, logic [7:0] pos);
         table_answer_type   a;
         int                 k, lo, hi, mid, last;
         bit                 swapped;
         logic signed [31:0] t;
         a.status = ate_pkg::ST_OK;
         a.found_index = '0;
         case (op)
            ate_pkg::OP_APPEND: begin
               if (cnt < limit()) begin
                  tbl[cnt] = v;
                  cnt++;
               end else a.status = ate_pkg::ST_FULL;
            end
            ate_pkg::OP_INSERT_AT: begin
               if (int'(pos) > cnt) a.status = ate_pkg::ST_BAD_POS;
               else if (cnt >= limit()) a.status = ate_pkg::ST_FULL;
               else begin
                  for (k = cnt; k > int'(pos); k--) tbl[k] = tbl[k-1];
                  tbl[pos] = v;
                  cnt++;
               end
            end
            ate_pkg::OP_REMOVE_FIRST: begin
               a.status = ate_pkg::ST_NOT_FOUND;
               for (k = 0; k < cnt; k++) begin
                  if (tbl[k] == v) begin
                     drop(k);
                     a.status = ate_pkg::ST_OK;
                     break;
                  end
               end
            end
            ate_pkg::OP_REMOVE_ALL: begin
               a.status = ate_pkg::ST_NOT_FOUND;
               k = 0;
               while (k < cnt) begin
                  if (tbl[k] == v) begin
                     drop(k);
                     a.status = ate_pkg::ST_OK;
                  end else k++;
               end
            end
            ate_pkg::OP_REMOVE_AT: begin
               if (int'(pos) >= cnt) a.status = ate_pkg::ST_BAD_POS;
               else drop(pos);
            end
            ate_pkg::OP_FIND: begin
               a.status = ate_pkg::ST_NOT_FOUND;
               for (k = 0; k < cnt; k++) begin
                  if (tbl[k] == v) begin
                     a.found_index = k[7:0];
                     a.status = ate_pkg::ST_OK;
                     break;
                  end
               end
            end
            ate_pkg::OP_BSEARCH: begin
               a.status = ate_pkg::ST_NOT_FOUND;
               lo = 0;
               hi = cnt - 1;
               while (lo <= hi) begin
                  mid = (lo + hi) / 2;
                  if (tbl[mid] == v) begin
                     a.found_index = mid[7:0];
                     a.status = ate_pkg::ST_OK;
                     break;
                  end else if (v < tbl[mid]) hi = mid - 1;
                  else lo = mid + 1;
               end
            end
            default: begin
               for (last = cnt; last > 1; last--) begin
                  swapped = 0;
                  for (k = 0; k + 1 < last; k++) begin
                     if (tbl[k+1] < tbl[k]) begin
                        t = tbl[k];
                        tbl[k] = tbl[k+1];
                        tbl[k+1] = t;
                        swapped = 1;
                     end
                  end
                  if (!swapped) break;
               end
            end
         endcase
         a.entry_count = cnt[8:0];
         expected_answers.push_back(a);
      endfunction

      function void check_result(logic [1:0] st, logic [7:0] fi, logic [8:0] ec);
         table_answer_type a;
         if (expected_answers.size() == 0) begin
            $error("unexpected response transfer");
            errors++;
            return;
         end
         a = expected_answers.pop_front();
         if (st !== a.status) begin
            $error("status: expected %0d actual %0d", a.status, st);
            errors++;
         end
         if (fi !== a.found_index) begin
            $error("found_index: expected %0d actual %0d", a.found_index, fi);
            errors++;
         end
         if (ec !== a.entry_count) begin
            $error("entry_count: expected %0d actual %0d", a.entry_count, ec);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [2:0]         req_operation = ate_pkg::OP_APPEND;
   logic signed [31:0] req_value = '0;
   logic [7:0]         req_position = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic [1:0]         rsp_status;
   logic [7:0]         rsp_found_index;
   logic [8:0]         rsp_entry_count;
   logic               psel = 0;
   logic               penable = 0;
   logic               pwrite = 0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   table_scoreboard sb = new();
   bit              idle_on = 1;
   bit              hold_now = 0;
   int              hold_left = 0;

   array_table_engine_core u_top (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   // response side: check, then pick next stall
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result(rsp_status, rsp_found_index, rsp_entry_count);
         if (hold_now) begin
            hold_left = 400;
            hold_now = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1;
         end else rsp_stall <= idle_on && ($urandom_range(99) < 35);
      end
   end

   task automatic send(logic [2:0] op, logic signed [31:0] v, logic [7:0] pos);
      if (idle_on && $urandom_range(99) < 35) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1;
      req_operation <= op;
      req_value <= v;
      req_position <= pos;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, v, pos);
   endtask

   task automatic set_capacity(logic [8:0] c);
      req_valid <= 0;
      @(posedge clock);
      while (sb.expected_answers.size() != 0) @(posedge clock);
      psel <= 1;
      pwrite <= 1;
      paddr <= CAP_ADDR;
      pwdata <= {23'd0, c};
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      sb.cap = c;
   endtask

   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 45 && sb.cnt > 0) return sb.tbl[$urandom_range(0, sb.cnt - 1)];
      if (r < 75) return $signed($urandom_range(0, 7)) - 4;
      return $urandom;
   endfunction

   task automatic random_item(int append_pct);
      logic [2:0] op;
      logic [7:0] pos;
      if ($urandom_range(99) < append_pct) op = ate_pkg::OP_APPEND;
      else begin
         op = 3'($urandom_range(1, 7));
         if (op == ate_pkg::OP_SORT && sb.cnt > 48) op = ate_pkg::OP_FIND;
      end
      if ($urandom_range(99) < 80) pos = 8'($urandom_range(0, (sb.cnt > 255) ? 255 : sb.cnt));
      else pos = 8'($urandom_range(0, 255));
      send(op, pick_value(), pos);
   endtask

   initial begin
      logic [8:0] caps [10] = '{9'd1, 9'd16, 9'd40, 9'd256, 9'd7,
                                9'd32, 9'd3, 9'd24, 9'd12, 9'd256};
      int         n;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(ate_pkg::OP_BSEARCH, 0, 0);
      send(ate_pkg::OP_APPEND, 32'sh8000_0000, 0);
      send(ate_pkg::OP_APPEND, 32'sh7FFF_FFFF, 0);
      send(ate_pkg::OP_APPEND, 0, 0);
      send(ate_pkg::OP_INSERT_AT, 1, 0);
      send(ate_pkg::OP_INSERT_AT, -1, 8'd255);
      send(ate_pkg::OP_INSERT_AT, 9, 4);
      send(ate_pkg::OP_REMOVE_AT, 0, 8'd255);
      send(ate_pkg::OP_FIND, 32'sh7FFF_FFFF, 0);
      send(ate_pkg::OP_FIND, 12345, 0);
      send(ate_pkg::OP_BSEARCH, 32'sh8000_0000, 0);
      send(ate_pkg::OP_SORT, 0, 0);
      send(ate_pkg::OP_BSEARCH, 9, 0);
      send(ate_pkg::OP_BSEARCH, 2, 0);
      send(ate_pkg::OP_REMOVE_AT, 0, 0);
      send(ate_pkg::OP_APPEND, 5, 0);
      send(ate_pkg::OP_APPEND, 5, 0);
      send(ate_pkg::OP_APPEND, 5, 0);
      send(ate_pkg::OP_REMOVE_ALL, 5, 0);
      send(ate_pkg::OP_REMOVE_FIRST, 77, 0);
      send(ate_pkg::OP_REMOVE_FIRST, 0, 0);
      set_capacity(9'd0);
      send(ate_pkg::OP_APPEND, 3, 0);
      send(ate_pkg::OP_INSERT_AT, 3, 0);
      send(ate_pkg::OP_INSERT_AT, 3, 8'd200);
      set_capacity(9'd2);
      send(ate_pkg::OP_APPEND, 4, 0);

      for (int p = 0; p < 10; p++) begin
         set_capacity(caps[p]);
         idle_on = (p != 2);
         n = (caps[p] == 256) ? 260 : 140;
         for (int i = 0; i < n; i++) begin
            if (p == 1 && i == 20) hold_now = 1;
            random_item((caps[p] == 256) ? 65 : 30);
         end
         if (caps[p] == 256) begin
            send(ate_pkg::OP_SORT, 0, 0);
            repeat (20) send(ate_pkg::OP_BSEARCH, pick_value(), 0);
            repeat (10) send(ate_pkg::OP_FIND, pick_value(), 0);
         end
      end

      req_valid <= 0;
      idle_on = 1;
      while (sb.expected_answers.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ate_pkg.sv
rtl/ate_ram.sv
rtl/ate_seq.sv
rtl/array_table_engine_core.sv
tb/tb_array_table_engine_core.sv
